// File: rtl/rtfca_pkg.sv
// Shared widths, constants and control types of the frame check and average block.
`timescale 1ns / 1ps

package rtfca_pkg;

    // Frame and report sizing
    localparam int MAX_SAMPLES = 16;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = WORD_W + $clog2(MAX_SAMPLES);

    // Stream word widths
    localparam int IN_W        = 6 * BYTE_W;
    localparam int HUM_W       = 14;
    localparam int TEMP_W      = 15;
    localparam int OUT_BITS    = HUM_W + TEMP_W + CNT_W + 1;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

    // CRC-8, MSB first
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam int CRC_BITS    = WORD_W;
    localparam int BIT_W       = $clog2(CRC_BITS);

    // Serial divider
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Scaling to hundredths
    localparam int SCALE_W     = 15;
    localparam int PROD_W      = WORD_W + SCALE_W;
    localparam int PROD_SHIFT  = 16;
    localparam logic [SCALE_W-1:0] HUM_SCALE   = 15'd10000;
    localparam logic [SCALE_W-1:0] TEMP_SCALE  = 15'd17500;
    localparam logic [TEMP_W-1:0]  TEMP_OFFSET = 15'd4500;

    // Configuration
    localparam logic [CNT_W-1:0] SPR_RESET = 5'd10;
    localparam logic [CNT_W-1:0] LIMIT_MIN = 5'd1;
    localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(MAX_SAMPLES);

    // CRC lane control
    typedef struct packed {
        logic load;
        logic step;
    } t_crc_ctl;

    // Divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: rtl/rtfca_crc.sv
// Bit-serial CRC-8 lane over one 16-bit word, high byte first.
`timescale 1ns / 1ps

module rtfca_crc import rtfca_pkg::*; (
    input  logic              i_clk,
    input  t_crc_ctl          i_ctl,
    input  logic [WORD_W-1:0] i_word,
    output logic [BYTE_W-1:0] o_crc
);

    logic [BYTE_W-1:0] r_crc;
    logic [WORD_W-1:0] r_shift;
    logic              w_fb;

    // feedback bit: CRC msb against next data bit
    assign w_fb = r_crc[BYTE_W-1] ^ r_shift[WORD_W-1];

    // one data bit per step
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_crc   <= CRC_INIT;
            r_shift <= i_word;
        end else if (i_ctl.step) begin
            r_crc   <= {r_crc[BYTE_W-2:0], 1'b0} ^ (w_fb ? CRC_POLY : '0);
            r_shift <= {r_shift[WORD_W-2:0], 1'b0};
        end
    end

    assign o_crc = r_crc;

endmodule

// File: rtl/rtfca_div.sv
// Restoring serial divider: 20-bit sum by 5-bit count, one quotient bit per cycle.
`timescale 1ns / 1ps

module rtfca_div import rtfca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctl          i_ctl,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output t_div_stat         o_stat,
    output logic [WORD_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_dvs;

    logic [CNT_W:0]       w_shift;
    logic [CNT_W:0]       w_diff;
    logic                 w_fit;

    // trial subtract of the divisor
    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_fit   = (w_shift >= {1'b0, r_dvs});

    // control: busy while the quotient bits are shifted in, then a done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // datapath: quotient shifts in from the bottom as the dividend leaves the top
    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    // average of words never exceeds a word
    assign o_quotient  = r_quo[WORD_W-1:0];

endmodule

// File: rtl/rh_temp_frame_check_average_unit.sv
// Top level: sensor frame CRC check, accumulation and averaged report in hundredths.
//
//   channel  dir  signals                          word
//   s        in   i_s_tvalid/o_s_tready/i_s_tdata  one six-byte sensor frame
//   m        out  o_m_tvalid/i_m_tready/o_m_tdata  one averaged report
//   cfg      in   i_cfg_valid/o_cfg_ready/i_cfg_data  frames per report
//
// A frame is accepted, run through the bit-serial CRC lanes and accumulated.
// A frame that closes a report then waits twice on the shared serial divider
// for its done pulse, passes two products through the shared multiplier, then
// the offset and the load into the output register. A report with no good
// frame skips the divides and products and goes straight to the load.
// Reset is synchronous and clears counters and sums and sets frames per
// report to 10; there is no clearing pass. A report waiting on o_m_tready
// does not block new frames; only the next report stalls until it is taken.
`timescale 1ns / 1ps

module rh_temp_frame_check_average_unit import rtfca_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // frame in: [7:0] rh_high, [15:8] rh_low, [23:16] rh_check,
    //           [31:24] temp_high, [39:32] temp_low, [47:40] temp_check
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,
    // report out: [13:0] humidity_centi, [28:14] temperature_centi (signed),
    //             [33:29] valid_count, [34] no_valid, [39:35] zero
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,
    // configuration: samples_per_report
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRC,
        ST_ACC,
        ST_DIV_H,
        ST_DIV_T,
        ST_MUL_H,
        ST_MUL_T,
        ST_FIN,
        ST_OUT
    } t_state;

    // control state
    t_state            r_state, n_state;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [CNT_W-1:0]  r_spr, n_spr;
    logic [CNT_W-1:0]  r_frame, n_frame;
    logic [CNT_W-1:0]  r_good, n_good;
    logic [SUM_W-1:0]  r_hsum, n_hsum;
    logic [SUM_W-1:0]  r_tsum, n_tsum;
    logic              r_o_valid, n_o_valid;

    // payload
    logic [WORD_W-1:0] r_rh_word, n_rh_word;
    logic [WORD_W-1:0] r_t_word, n_t_word;
    logic [BYTE_W-1:0] r_rh_chk, n_rh_chk;
    logic [BYTE_W-1:0] r_t_chk, n_t_chk;
    logic [WORD_W-1:0] r_havg, n_havg;
    logic [WORD_W-1:0] r_tavg, n_tavg;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [HUM_W-1:0]  r_hum, n_hum;
    logic [TEMP_W-1:0] r_tmp, n_tmp;
    logic              r_nv, n_nv;
    logic [OUT_W-1:0]  r_o_data, n_o_data;

    // shared units
    t_crc_ctl          crc_ctl;
    logic [BYTE_W-1:0] w_crc_h, w_crc_t;
    t_div_ctl          div_ctl;
    t_div_stat         div_stat;
    logic [SUM_W-1:0]  w_div_dividend;
    logic [CNT_W-1:0]  w_div_divisor;
    logic [WORD_W-1:0] w_quotient;
    logic [WORD_W-1:0] w_mul_a;
    logic [SCALE_W-1:0] w_mul_b;
    logic [PROD_W-1:0] w_mul;

    logic              w_good;
    logic [CNT_W-1:0]  w_limit;
    logic [CNT_W-1:0]  w_frame_inc;
    logic [CNT_W-1:0]  w_good_inc;
    logic [SUM_W-1:0]  w_hsum_add;
    logic [SUM_W-1:0]  w_tsum_add;
    logic              w_out_free;

    // CRC lanes, one per word, stepped together
    rtfca_crc u_crc_h (
        .i_clk  (i_clk),
        .i_ctl  (crc_ctl),
        .i_word ({i_s_tdata[BYTE_W-1:0], i_s_tdata[2*BYTE_W-1:BYTE_W]}),
        .o_crc  (w_crc_h)
    );

    rtfca_crc u_crc_t (
        .i_clk  (i_clk),
        .i_ctl  (crc_ctl),
        .i_word ({i_s_tdata[4*BYTE_W-1:3*BYTE_W], i_s_tdata[5*BYTE_W-1:4*BYTE_W]}),
        .o_crc  (w_crc_t)
    );

    // shared divider: humidity sum first, then temperature sum
    assign w_div_dividend = (r_state == ST_ACC) ? n_hsum : r_tsum;
    // the count of this frame is not registered yet when the first division starts
    assign w_div_divisor  = (r_state == ST_ACC) ? w_good_inc : r_good;

    rtfca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_stat     (div_stat),
        .o_quotient (w_quotient)
    );

    // shared multiplier, registered into r_prod
    assign w_mul_a = (r_state == ST_MUL_H) ? r_havg : r_tavg;
    assign w_mul_b = (r_state == ST_MUL_H) ? HUM_SCALE : TEMP_SCALE;
    assign w_mul   = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // frame verdict and accumulator updates
    assign w_good      = (w_crc_h == r_rh_chk) && (w_crc_t == r_t_chk);
    assign w_frame_inc = r_frame + 1'b1;
    assign w_good_inc  = r_good + (w_good ? CNT_W'(1) : CNT_W'(0));
    assign w_hsum_add  = r_hsum + (w_good ? SUM_W'(r_rh_word) : SUM_W'(0));
    assign w_tsum_add  = r_tsum + (w_good ? SUM_W'(r_t_word) : SUM_W'(0));

    // effective frames per report: zero means one, clamp at the maximum
    always_comb begin
        if (r_spr == '0) begin
            w_limit = LIMIT_MIN;
        end else if (r_spr > LIMIT_MAX) begin
            w_limit = LIMIT_MAX;
        end else begin
            w_limit = r_spr;
        end
    end

    assign w_out_free = !r_o_valid || i_m_tready;

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_bit     = r_bit;
        n_spr     = r_spr;
        n_frame   = r_frame;
        n_good    = r_good;
        n_hsum    = r_hsum;
        n_tsum    = r_tsum;
        n_o_valid = r_o_valid;
        n_rh_word = r_rh_word;
        n_t_word  = r_t_word;
        n_rh_chk  = r_rh_chk;
        n_t_chk   = r_t_chk;
        n_havg    = r_havg;
        n_tavg    = r_tavg;
        n_prod    = r_prod;
        n_hum     = r_hum;
        n_tmp     = r_tmp;
        n_nv      = r_nv;
        n_o_data  = r_o_data;
        crc_ctl   = '0;
        div_ctl   = '0;

        if (i_cfg_valid) begin
            n_spr = i_cfg_data;
        end

        // report word taken
        if (r_o_valid && i_m_tready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_rh_word    = {i_s_tdata[BYTE_W-1:0], i_s_tdata[2*BYTE_W-1:BYTE_W]};
                    n_rh_chk     = i_s_tdata[3*BYTE_W-1:2*BYTE_W];
                    n_t_word     = {i_s_tdata[4*BYTE_W-1:3*BYTE_W],
                                    i_s_tdata[5*BYTE_W-1:4*BYTE_W]};
                    n_t_chk      = i_s_tdata[6*BYTE_W-1:5*BYTE_W];
                    crc_ctl.load = 1'b1;
                    n_bit        = '0;
                    n_state      = ST_CRC;
                end
            end
            ST_CRC: begin
                crc_ctl.step = 1'b1;
                n_bit        = r_bit + 1'b1;
                if (r_bit == BIT_W'(CRC_BITS - 1)) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_frame = w_frame_inc;
                n_good  = w_good_inc;
                n_hsum  = w_hsum_add;
                n_tsum  = w_tsum_add;
                if (w_frame_inc >= w_limit) begin
                    if (w_good_inc == '0) begin
                        // no good frame: zero averages, flag set
                        n_hum   = '0;
                        n_tmp   = '0;
                        n_nv    = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        div_ctl.start = 1'b1;
                        n_state       = ST_DIV_H;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV_H: begin
                if (div_stat.done) begin
                    n_havg        = w_quotient;
                    div_ctl.start = 1'b1;
                    n_state       = ST_DIV_T;
                end
            end
            ST_DIV_T: begin
                if (div_stat.done) begin
                    n_tavg  = w_quotient;
                    n_state = ST_MUL_H;
                end
            end
            ST_MUL_H: begin
                n_prod  = w_mul;
                n_state = ST_MUL_T;
            end
            ST_MUL_T: begin
                n_hum   = r_prod[PROD_SHIFT +: HUM_W];
                n_prod  = w_mul;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                // wraps to two's complement; true result lies in -4500..12999
                n_tmp   = r_prod[PROD_SHIFT +: TEMP_W] - TEMP_OFFSET;
                n_nv    = 1'b0;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_data  = {{(OUT_W - OUT_BITS){1'b0}}, r_nv, r_good, r_tmp, r_hum};
                    n_frame   = '0;
                    n_good    = '0;
                    n_hsum    = '0;
                    n_tsum    = '0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bit     <= '0;
            r_spr     <= SPR_RESET;
            r_frame   <= '0;
            r_good    <= '0;
            r_hsum    <= '0;
            r_tsum    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bit     <= n_bit;
            r_spr     <= n_spr;
            r_frame   <= n_frame;
            r_good    <= n_good;
            r_hsum    <= n_hsum;
            r_tsum    <= n_tsum;
            r_o_valid <= n_o_valid;
            r_rh_word <= n_rh_word;
            r_t_word  <= n_t_word;
            r_rh_chk  <= n_rh_chk;
            r_t_chk   <= n_t_chk;
            r_havg    <= n_havg;
            r_tavg    <= n_tavg;
            r_prod    <= n_prod;
            r_hum     <= n_hum;
            r_tmp     <= n_tmp;
            r_nv      <= n_nv;
            r_o_data  <= n_o_data;
        end
    end

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_o_valid;
    assign o_m_tdata   = r_o_data;
    assign o_cfg_ready = 1'b1;

    // frame count never runs past the largest report size
    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame <= LIMIT_MAX)
        else $error("frame count past maximum");

    // good frames never outnumber frames
    a_good_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_good <= r_frame)
        else $error("good count exceeds frame count");

    // divider finishes only while the sequencer waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ST_DIV_H || r_state == ST_DIV_T))
        else $error("divider done outside a divide step");

    // loading a report clears the accumulation and shows the word
    a_report_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && w_out_free) |=>
            (r_frame == '0 && r_hsum == '0 && r_tsum == '0 && o_m_tvalid))
        else $error("report load left state behind");

endmodule
